// ----- rtl/core/fdps_pkg.sv -----
// Shared constants for the fractional delay pitch shifter.
package fdps_pkg;

    localparam int SAMPLE_W = 24;
    localparam int STEP_W   = 20;

    localparam int DEFAULT_RING_DEPTH    = 4096;
    localparam int DEFAULT_FRACTION_BITS = 16;

    // 0.5 with 16 fraction bits
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd32768;

endpackage

// ----- rtl/core/fdps_ifs.sv -----
// Valid/ready channel interfaces for samples in, samples out and the step register.
interface fdps_in_if;
    import fdps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdps_out_if;
    import fdps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdps_cfg_if;
    import fdps_pkg::*;

    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] delay_step;

    modport source (output valid, output delay_step, input ready);
    modport sink   (input valid, input delay_step, output ready);
endinterface

// ----- rtl/core/fdps_ram.sv -----
// Generic single-write, single-read RAM with registered, read-enabled output.
module fdps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/fractional_delay_pitch_shifter.sv -----
// Top level: ring-buffer fractional delay line with linear interpolation.
//
//  channel   modport  payload              transfer when
//  -------   -------  -------------------  ---------------------------
//  samples   sink     sample_in  (s24)     samples.valid && samples.ready
//  shifted   source   sample_out (s24)     shifted.valid && shifted.ready
//  cfg       sink     delay_step (u20)     cfg.valid && cfg.ready
//
//  One sample per cycle while shifted.ready is high and no step is being reduced;
//  a sample passes ring read, multiply and round/output registers to output valid.
//  The ring is held twice (two 1W1R RAMs) so both interpolation taps are read
//  in the cycle of the input transfer; the write of that sample lands at the
//  same edge with read-before-write, so the taps see the ring before the write.
//  No clearing pass after reset: entries not yet written since reset read as
//  zero by comparing against the write pointer and a wrap flag.
//  A step write whose value may exceed the accumulator modulus is reduced by
//  one compare/subtract per cycle; samples.ready and cfg.ready stay low for
//  those cycles (none at the default size).
//  Stalls: each stage holds while the one after it is full and stalled; with
//  all stages full and shifted.ready low, samples.ready drops.
module fractional_delay_pitch_shifter #(
    parameter int RING_DEPTH    = fdps_pkg::DEFAULT_RING_DEPTH,
    parameter int FRACTION_BITS = fdps_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    fdps_in_if.sink     samples,
    fdps_out_if.source  shifted,
    fdps_cfg_if.sink    cfg
);
    import fdps_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int ACC_W = IDX_W + FRACTION_BITS;
    localparam longint unsigned ACC_MOD = 64'(RING_DEPTH) << FRACTION_BITS;
    localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam logic [SUM_W-1:0] ACC_MOD_S = SUM_W'(ACC_MOD);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(RING_DEPTH);

    // step reduction: restoring subtract of the modulus shifted down one bit a cycle
    localparam int RED_W = STEP_W + 1;
    localparam int RED_STEPS = (ACC_MOD >= (64'd1 << STEP_W)) ? 0
                               : STEP_W - $clog2(ACC_MOD) + 1;
    localparam int RED_STEPS_C = (RED_STEPS > 0) ? RED_STEPS : 1;
    localparam int CNT_W = $clog2(RED_STEPS_C + 1);
    localparam logic [RED_W-1:0] DIV_INIT = RED_W'(ACC_MOD << (RED_STEPS_C - 1));
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(RED_STEPS);
    localparam logic [STEP_W-1:0] STEP_RESET_MOD =
        STEP_W'(64'(STEP_RESET) % ACC_MOD);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
    localparam int MAC_W  = PROD_W + 1;
    localparam logic signed [MAC_W-1:0] HALF = MAC_W'(1) << (FRACTION_BITS - 1);

    // ---------------- control state ----------------
    logic [IDX_W-1:0]  wi_reg,      wi_next;
    logic              wrapped_reg, wrapped_next;
    logic [ACC_W-1:0]  acc_reg,     acc_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic [RED_W-1:0]  red_div_reg, red_div_next;
    logic [CNT_W-1:0]  red_cnt_reg, red_cnt_next;
    logic              s1_v_reg,    s1_v_next;
    logic              s2_v_reg,    s2_v_next;
    logic              out_v_reg,   out_v_next;

    logic busy;
    logic accept;
    logic cfg_write;
    logic adv1, adv2, adv_out;

    // ---------------- issue stage ----------------
    logic [IDX_W-1:0]         ipart;
    logic [FRACTION_BITS-1:0] frac_s0;
    logic [IDX_W:0]           rd_wide;
    logic [IDX_W-1:0]         rd_idx, nx_idx;
    logic                     rd_ok, nx_ok;
    logic [SUM_W-1:0]         acc_sum, acc_wrap;

    // ---------------- pipeline payload ----------------
    logic [SAMPLE_W-1:0]         ram_a, ram_b;
    logic [FRACTION_BITS-1:0]    s1_frac_reg;
    logic                        s1_aok_reg, s1_bok_reg;
    logic signed [SAMPLE_W-1:0]  s1_a, s1_b;
    logic signed [DIFF_W-1:0]    s1_diff;
    logic signed [PROD_W-1:0]    s1_prod;
    logic signed [PROD_W-1:0]    s2_prod_reg;
    logic signed [SAMPLE_W-1:0]  s2_a_reg;
    logic signed [MAC_W-1:0]     s2_mac;
    logic signed [SAMPLE_W-1:0]  out_data_reg;

    // ---------------- handshakes ----------------
    assign busy      = (red_cnt_reg != '0);
    assign adv_out   = !out_v_reg || shifted.ready;
    assign adv2      = !s2_v_reg || adv_out;
    assign adv1      = !s1_v_reg || adv2;
    assign samples.ready = adv1 && !busy;
    assign cfg.ready = !busy;
    assign accept    = samples.valid && samples.ready;
    assign cfg_write = cfg.valid && cfg.ready;

    assign shifted.valid      = out_v_reg;
    assign shifted.sample_out = out_data_reg;

    // ---------------- read addresses ----------------
    assign ipart   = acc_reg[ACC_W-1:FRACTION_BITS];
    assign frac_s0 = acc_reg[FRACTION_BITS-1:0];

    always_comb
    begin
        if (wi_reg >= ipart)
        begin
            rd_wide = {1'b0, wi_reg} - {1'b0, ipart};
        end
        else
        begin
            rd_wide = {1'b0, wi_reg} + DEPTH_X - {1'b0, ipart};
        end
        rd_idx = rd_wide[IDX_W-1:0];
        nx_idx = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
    end

    // entries at or past the write pointer are unwritten until the first wrap
    assign rd_ok = wrapped_reg || (rd_idx < wi_reg);
    assign nx_ok = wrapped_reg || (nx_idx < wi_reg);

    // ---------------- accumulator / pointer / step update ----------------
    assign acc_sum  = SUM_W'(acc_reg) + SUM_W'(step_reg);
    assign acc_wrap = (acc_sum >= ACC_MOD_S) ? acc_sum - ACC_MOD_S : acc_sum;

    always_comb
    begin
        wi_next      = wi_reg;
        wrapped_next = wrapped_reg;
        acc_next     = acc_reg;
        if (accept)
        begin
            acc_next = acc_wrap[ACC_W-1:0];
            if (wi_reg == LAST_IDX)
            begin
                wi_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wi_next = wi_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        step_next    = step_reg;
        red_div_next = red_div_reg;
        red_cnt_next = red_cnt_reg;
        if (cfg_write)
        begin
            step_next    = cfg.delay_step;
            red_div_next = DIV_INIT;
            red_cnt_next = CNT_INIT;
        end
        else if (busy)
        begin
            if ({1'b0, step_reg} >= red_div_reg)
            begin
                step_next = step_reg - red_div_reg[STEP_W-1:0];
            end
            red_div_next = red_div_reg >> 1;
            red_cnt_next = red_cnt_reg - 1'b1;
        end
    end

    // ---------------- pipeline valids ----------------
    assign s1_v_next  = adv1    ? accept   : s1_v_reg;
    assign s2_v_next  = adv2    ? s1_v_reg : s2_v_reg;
    assign out_v_next = adv_out ? s2_v_reg : out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
            acc_reg     <= '0;
            step_reg    <= STEP_RESET_MOD;
            red_div_reg <= '0;
            red_cnt_reg <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            wi_reg      <= wi_next;
            wrapped_reg <= wrapped_next;
            acc_reg     <= acc_next;
            step_reg    <= step_next;
            red_div_reg <= red_div_next;
            red_cnt_reg <= red_cnt_next;
            s1_v_reg    <= s1_v_next;
            s2_v_reg    <= s2_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    // ---------------- ring storage: two copies, one per tap ----------------
    fdps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_a (
        .clk   (clk),
        .we    (accept),
        .waddr (wi_reg),
        .wdata (samples.sample_in),
        .re    (adv1),
        .raddr (rd_idx),
        .rdata (ram_a)
    );

    fdps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_b (
        .clk   (clk),
        .we    (accept),
        .waddr (wi_reg),
        .wdata (samples.sample_in),
        .re    (adv1),
        .raddr (nx_idx),
        .rdata (ram_b)
    );

    // ---------------- stage 1: taps -> frac*(b-a) product ----------------
    assign s1_a    = s1_aok_reg ? $signed(ram_a) : '0;
    assign s1_b    = s1_bok_reg ? $signed(ram_b) : '0;
    assign s1_diff = DIFF_W'(s1_b) - DIFF_W'(s1_a);
    assign s1_prod = $signed({1'b0, s1_frac_reg}) * s1_diff;

    // ---------------- stage 2: add a*2^F, round half up, shift ----------------
    assign s2_mac = (MAC_W'(s2_a_reg) <<< FRACTION_BITS) + MAC_W'(s2_prod_reg) + HALF;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_frac_reg <= frac_s0;
            s1_aok_reg  <= rd_ok;
            s1_bok_reg  <= nx_ok;
        end
        if (adv2)
        begin
            s2_prod_reg <= s1_prod;
            s2_a_reg    <= s1_a;
        end
        if (adv_out)
        begin
            out_data_reg <= s2_mac[FRACTION_BITS +: SAMPLE_W];
        end
    end

`ifndef ASSERT_OFF
    // an accepted sample always occupies the tap stage on the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_v_reg)
        else $error("accepted sample missing from tap stage");

    // tap data must hold while stage 1 is stalled (RAM read enable gating)
    a_taps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && !adv2) |=> ($stable(s1_a) && $stable(s1_b)))
        else $error("tap data changed during stall");

    // accumulator stays below the modulus
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(acc_reg) < ACC_MOD_S)
        else $error("delay accumulator out of range");

    // no sample is taken while a step write is still being reduced
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (CNT_INIT != '0) |=> !accept)
        else $error("sample accepted during step reduction");
`endif

endmodule
